>>> rtl/core/pift_pkg.sv
// shared constants and types for the point-in-figures tester
`default_nettype none
package pift_pkg;
   localparam int MaxShapes  = 16;
   localparam int CoordWidth = 24;
   localparam int IdxWidth   = $clog2(MaxShapes);
   localparam int CntWidth   = $clog2(MaxShapes + 1);
   localparam int FigWidth   = 5;
   localparam int PointWidth = 16;
   localparam int DiffWidth  = CoordWidth + 1;
   localparam int ProdWidth  = 2 * DiffWidth;
   localparam int EntryWidth = 2 + 7 * CoordWidth - 1;

   localparam logic [1:0] KindRect   = 2'd0;
   localparam logic [1:0] KindCircle = 2'd1;

   typedef struct packed {
      logic [1:0]            kind;
      logic [CoordWidth-1:0] first_x;
      logic [CoordWidth-1:0] first_y;
      logic [CoordWidth-1:0] second_x;
      logic [CoordWidth-1:0] second_y;
      logic [CoordWidth-1:0] third_x;
      logic [CoordWidth-1:0] third_y;
      logic [CoordWidth-2:0] radius;
   } entry_type;

   typedef struct packed {
      logic                  valid;
      logic                  last;
      logic [IdxWidth-1:0]   idx;
   } probe_type;
endpackage
`default_nettype wire

>>> rtl/core/point_in_figures_tester.sv
// top level of the point-in-figures tester
// Usage: a request on req_ either loads a figure (action 0) or tests a point
// (action 1). A load writes the next table entry and gives no response;
// with the table full it is dropped. Loads can follow back to back.
// A test numbers the point, then walks the table one figure per cycle while
// the walk is not frozen: the figure table ram is read once per figure and
// each read passes a three-stage test pipeline. Every containing figure
// yields one response on rsp_ in table order; if none contains the point
// one response with figure number 0 is sent. rsp_tlast marks the final
// response of a point. A new request is taken only once the last response
// has left, so tests never overlap.
// A hit is held back until a later hit or the end of the walk shows whether
// it is the final one. When the receiver stalls and a second hit is waiting,
// the whole walk freezes until the response register frees; nothing is lost.
// Reset clears the figure count and point counter; table contents need no
// clearing since only results from loaded entries are ever used.
`default_nettype none
module point_in_figures_tester (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // tdata: first_x, first_y, second_x, second_y, third_x, third_y, radius,
   //        point_x, point_y (low to high), zero padded
   input  wire [215:0] req_tdata,
   // tuser: action, figure_kind (low to high)
   input  wire [2:0]   req_tuser,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // tdata: point_number, figure_number, contained (low to high), zero padded
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast
);
   localparam int CW = pift_pkg::CoordWidth;
   localparam int IW = pift_pkg::IdxWidth;
   localparam int NW = pift_pkg::CntWidth;
   localparam int FW = pift_pkg::FigWidth;
   localparam int PxLsb = 7 * CW - 1;
   localparam int PyLsb = PxLsb + CW;

   localparam logic [1:0] StIdle  = 2'd0;
   localparam logic [1:0] StWalk  = 2'd1;
   localparam logic [1:0] StFlush = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [NW-1:0] count_ff, count_in;
   logic [pift_pkg::PointWidth-1:0] pnum_ff, pnum_in;
   logic [NW-1:0] idx_ff, idx_in;
   logic [CW-1:0] px_ff, py_ff;

   // latest hit, not yet known to be last
   logic          held_ff, held_in;
   logic [FW-1:0] held_fig_ff, held_fig_in;

   // response register
   logic          out_valid_ff, out_valid_in;
   logic [FW-1:0] out_fig_ff, out_fig_in;
   logic          out_hit_ff, out_hit_in;
   logic          out_last_ff, out_last_in;

   pift_pkg::entry_type wr_entry, rd_entry;
   pift_pkg::probe_type probe_ff, probe_in, done;
   logic hit;
   logic wr_en;
   logic test_take;
   logic out_free;
   logic advance;

   always_comb begin
      wr_entry.kind     = req_tuser[2:1];
      wr_entry.first_x  = req_tdata[0*CW +: CW];
      wr_entry.first_y  = req_tdata[1*CW +: CW];
      wr_entry.second_x = req_tdata[2*CW +: CW];
      wr_entry.second_y = req_tdata[3*CW +: CW];
      wr_entry.third_x  = req_tdata[4*CW +: CW];
      wr_entry.third_y  = req_tdata[5*CW +: CW];
      wr_entry.radius   = req_tdata[6*CW +: CW-1];
   end

   assign req_tready = (state_ff == StIdle) && !out_valid_ff;
   assign test_take  = req_tvalid && req_tready && req_tuser[0];
   assign wr_en = req_tvalid && req_tready && !req_tuser[0] &&
                  (count_ff < NW'(pift_pkg::MaxShapes));

   // a second hit with the response register busy freezes the walk
   assign out_free = !out_valid_ff || rsp_tready;
   assign advance  = !(done.valid && hit && held_ff && !out_free);

   pift_ram #(.Width(pift_pkg::EntryWidth), .Depth(pift_pkg::MaxShapes)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IW-1:0]),
      .wr_data (wr_entry),
      .rd_en   (advance),
      .rd_addr (idx_ff[IW-1:0]),
      .rd_data (rd_entry)
   );

   pift_eval u_eval (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .probe   (probe_ff),
      .entry   (rd_entry),
      .px      (signed'(px_ff)),
      .py      (signed'(py_ff)),
      .done    (done),
      .hit     (hit)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pnum_in      = pnum_ff;
      idx_in       = idx_ff;
      held_in      = held_ff;
      held_fig_in  = held_fig_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_fig_in   = out_fig_ff;
      out_hit_in   = out_hit_ff;
      out_last_in  = out_last_ff;
      probe_in     = '0;
      case (state_ff)
         StIdle: begin
            if (test_take) begin
               pnum_in  = pnum_ff + 1'b1;
               idx_in   = '0;
               held_in  = 1'b0;
               state_in = (count_ff == '0) ? StFlush : StWalk;
            end else if (wr_en) begin
               count_in = count_ff + 1'b1;
            end
         end
         StWalk: begin
            if (idx_ff < count_ff) begin
               probe_in.valid = 1'b1;
               probe_in.idx   = idx_ff[IW-1:0];
               probe_in.last  = (idx_ff == count_ff - NW'(1));
               if (advance) idx_in = idx_ff + 1'b1;
            end
            if (done.valid && advance) begin
               if (hit) begin
                  // the previous hit is now known not to be last
                  if (held_ff) begin
                     out_valid_in = 1'b1;
                     out_fig_in   = held_fig_ff;
                     out_hit_in   = 1'b1;
                     out_last_in  = 1'b0;
                  end
                  held_in     = 1'b1;
                  held_fig_in = FW'(done.idx) + FW'(1);
               end
               if (done.last) state_in = StFlush;
            end
         end
         StFlush: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_fig_in   = held_ff ? held_fig_ff : '0;
               out_hit_in   = held_ff;
               out_last_in  = 1'b1;
               held_in      = 1'b0;
               state_in     = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         count_ff     <= '0;
         pnum_ff      <= '0;
         probe_ff     <= '0;
         idx_ff       <= '0;
         held_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pnum_ff      <= pnum_in;
         idx_ff       <= idx_in;
         held_ff      <= held_in;
         out_valid_ff <= out_valid_in;
         if (advance) probe_ff <= probe_in;
      end
   end

   always_ff @(posedge clock) begin
      held_fig_ff <= held_fig_in;
      out_fig_ff  <= out_fig_in;
      out_hit_ff  <= out_hit_in;
      out_last_ff <= out_last_in;
      if (test_take) begin
         px_ff <= req_tdata[PxLsb +: CW];
         py_ff <= req_tdata[PyLsb +: CW];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b0, out_hit_ff, out_fig_ff, pnum_ff};
   assign rsp_tlast  = out_last_ff;
endmodule
`default_nettype wire

>>> rtl/core/pift_ram.sv
// generic single-port-write ram with registered read
`default_nettype none
module pift_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(Depth)-1:0]  wr_addr,
   input  wire [Width-1:0]          wr_data,
   input  wire                      rd_en,
   input  wire [$clog2(Depth)-1:0]  rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

>>> rtl/core/pift_eval.sv
// pipelined containment test of one stored figure against the point
`default_nettype none
module pift_eval (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 advance,
   input  pift_pkg::probe_type                 probe,
   input  pift_pkg::entry_type                 entry,
   input  wire signed [pift_pkg::CoordWidth-1:0] px,
   input  wire signed [pift_pkg::CoordWidth-1:0] py,
   output pift_pkg::probe_type                 done,
   output logic                                hit
);
   localparam int DW = pift_pkg::DiffWidth;
   localparam int PW = pift_pkg::ProdWidth;

   // stage 1: differences and rectangle compare
   pift_pkg::probe_type  s1_ff;
   logic [1:0]           kind1_ff;
   logic                 rect1_ff;
   logic signed [DW-1:0] dx1_ff, dy1_ff, ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff;
   logic signed [DW-1:0] qx_ff, qy_ff, ex_ff, ey_ff;
   logic [pift_pkg::CoordWidth-2:0] r1_ff;

   // stage 2: products
   pift_pkg::probe_type  s2_ff;
   logic [1:0]           kind2_ff;
   logic                 rect2_ff;
   logic signed [PW-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff, p6_ff, p7_ff;
   logic signed [PW-1:0] sq_x_ff, sq_y_ff, rr_ff;

   // stage 3: result
   pift_pkg::probe_type  s3_ff;
   logic                 hit_ff;

   logic signed [DW-1:0] x1, y1, x2, y2, x3, y3, ppx, ppy;
   logic signed [PW:0]   c1, c2, c3, c4, dist_sq;
   logic                 tri_hit, circ_hit;

   always_comb begin
      x1  = DW'(signed'(entry.first_x));
      y1  = DW'(signed'(entry.first_y));
      x2  = DW'(signed'(entry.second_x));
      y2  = DW'(signed'(entry.second_y));
      x3  = DW'(signed'(entry.third_x));
      y3  = DW'(signed'(entry.third_y));
      ppx = DW'(px);
      ppy = DW'(py);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         // cross(v1,v2,p): (v2-v1)x(p-v1); cross(v1,v3,p); cross(v2,v1,p); cross(v2,v3,p)
         dx1_ff   <= ppx - x1;
         dy1_ff   <= ppy - y1;
         ax_ff    <= x2 - x1;
         ay_ff    <= y2 - y1;
         bx_ff    <= x3 - x1;
         by_ff    <= y3 - y1;
         qx_ff    <= ppx - x2;
         qy_ff    <= ppy - y2;
         cx_ff    <= x1 - x2;
         cy_ff    <= y1 - y2;
         ex_ff    <= x3 - x2;
         ey_ff    <= y3 - y2;
         r1_ff    <= entry.radius;
         kind1_ff <= entry.kind;
         rect1_ff <= (ppx > x1) && (ppx < x2) && (ppy < y1) && (ppy > y2);

         p0_ff    <= PW'(ax_ff) * PW'(dy1_ff);
         p1_ff    <= PW'(ay_ff) * PW'(dx1_ff);
         p2_ff    <= PW'(bx_ff) * PW'(dy1_ff);
         p3_ff    <= PW'(by_ff) * PW'(dx1_ff);
         p4_ff    <= PW'(cx_ff) * PW'(qy_ff);
         p5_ff    <= PW'(cy_ff) * PW'(qx_ff);
         p6_ff    <= PW'(ex_ff) * PW'(qy_ff);
         p7_ff    <= PW'(ey_ff) * PW'(qx_ff);
         sq_x_ff  <= PW'(dx1_ff) * PW'(dx1_ff);
         sq_y_ff  <= PW'(dy1_ff) * PW'(dy1_ff);
         rr_ff    <= PW'({1'b0, r1_ff}) * PW'({1'b0, r1_ff});
         kind2_ff <= kind1_ff;
         rect2_ff <= rect1_ff;

         case (kind2_ff)
            pift_pkg::KindRect:   hit_ff <= rect2_ff;
            pift_pkg::KindCircle: hit_ff <= circ_hit;
            default:              hit_ff <= tri_hit;
         endcase
      end
   end

   always_comb begin
      c1   = (PW+1)'(p0_ff) - (PW+1)'(p1_ff);
      c2   = (PW+1)'(p2_ff) - (PW+1)'(p3_ff);
      c3   = (PW+1)'(p4_ff) - (PW+1)'(p5_ff);
      c4   = (PW+1)'(p6_ff) - (PW+1)'(p7_ff);
      dist_sq = (PW+1)'(sq_x_ff) + (PW+1)'(sq_y_ff);
      circ_hit = dist_sq < (PW+1)'(rr_ff);
      tri_hit  = (c1 != 0) && (c2 != 0) && (c1[PW] != c2[PW]) &&
                 (c3 != 0) && (c4 != 0) && (c3[PW] != c4[PW]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
         s3_ff <= '0;
      end else if (advance) begin
         s1_ff <= probe;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
      end
   end

   assign done = s3_ff;
   assign hit  = hit_ff;
endmodule
`default_nettype wire

>>> rtl/core/pift_checker.sv
// port-level checker for the point-in-figures tester
`default_nettype none
module pift_checker (
   input wire         clock,
   input wire         reset,
   input wire         req_tvalid,
   input wire         req_tready,
   input wire         rsp_tvalid,
   input wire         rsp_tready,
   input wire [23:0]  rsp_tdata,
   input wire         rsp_tlast
);
   // a point with no containing figure ends its run at once
   a_miss_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[21] |-> rsp_tlast) else $error("miss not last");
   // a hit response names a figure
   a_hit_fig: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[21] |-> rsp_tdata[20:16] != 5'd0) else $error("hit w/o figure");
   // no new request while responses are pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("request taken during response");
   // stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)) else $error("stall lost");
endmodule
bind point_in_figures_tester pift_checker u_checker (.*);
`default_nettype wire

>>> verif/tb_point_in_figures_tester.sv
// self-checking testbench for the point-in-figures tester: random figures and points
`timescale 1ns / 100ps
`default_nettype none
module tb_point_in_figures_tester;
   localparam logic ActLoad = 1'b0;
   localparam logic ActTest = 1'b1;
   localparam logic [1:0] KindTri = 2'd2;
   localparam logic [1:0] KindSpare = 2'd3;

   typedef struct {
      logic       action;
      logic [1:0] kind;
      logic signed [23:0] x1, y1, x2, y2, x3, y3;
      logic [22:0] rad;
      logic signed [23:0] px, py;
   } request_type;

   typedef struct {
      logic [15:0] point_no;
      logic [4:0]  fig_no;
      logic        hit;
      logic        last;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic [215:0] req_tdata = '0;
   logic [2:0] req_tuser = '0;
   logic rsp_tready = 1'b0;
   wire req_tready, rsp_tvalid, rsp_tlast;
   wire [23:0] rsp_tdata;

   point_in_figures_tester i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   always #10 clock = ~clock;

   request_type  pending_reqs[$];
   response_type expected_hits[$];
   request_type  fig_table[pift_pkg::MaxShapes];
   int        fig_count = 0;
   logic [15:0] point_count = '0;
   int  errors = 0;
   bit  stim_done = 1'b0;
   bit  hold_rsp = 1'b0;
   int  rsp_seen = 0;

   task automatic report(input string what);
      $display("error at %0t: %s", $realtime, what);
      errors++;
   endtask

   function automatic int sgn(input longint v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
   endfunction

   // sign of (a - c) x (b - c); 64-bit products are exact for 25-bit differences
   function automatic int cross_sgn(input longint cx, cy, ax, ay, bx, by);
      return sgn((ax - cx) * (by - cy) - (ay - cy) * (bx - cx));
   endfunction

   function automatic bit opp(input int s, input int t);
      return s != 0 && t != 0 && s != t;
   endfunction

   function automatic bit figure_holds(input request_type f, input longint px, py);
      longint x1, y1, x2, y2, x3, y3, r;
      x1 = f.x1; y1 = f.y1; x2 = f.x2; y2 = f.y2; x3 = f.x3; y3 = f.y3;
      r = f.rad;
      if (f.kind == pift_pkg::KindRect) return px > x1 && px < x2 && py < y1 && py > y2;
      if (f.kind == pift_pkg::KindCircle)
         return (px - x1) * (px - x1) + (py - y1) * (py - y1) < r * r;
      return opp(cross_sgn(x1, y1, x2, y2, px, py), cross_sgn(x1, y1, x3, y3, px, py)) &&
             opp(cross_sgn(x2, y2, x1, y1, px, py), cross_sgn(x2, y2, x3, y3, px, py));
   endfunction

   task automatic predict_hits(input request_type r);
      response_type e;
      int n;
      n = 0;
      if (r.action == ActLoad) begin
         if (fig_count < pift_pkg::MaxShapes) begin
            fig_table[fig_count] = r;
            fig_count++;
         end
         return;
      end
      point_count++;
      for (int i = 0; i < fig_count; i++) begin
         if (figure_holds(fig_table[i], r.px, r.py)) begin
            e.point_no = point_count; e.fig_no = 5'(i + 1); e.hit = 1'b1; e.last = 1'b0;
            expected_hits.push_back(e);
            n++;
         end
      end
      if (n == 0) begin
         e.point_no = point_count; e.fig_no = '0; e.hit = 1'b0; e.last = 1'b1;
         expected_hits.push_back(e);
      end else begin
         expected_hits[$].last = 1'b1;
      end
   endtask

   function automatic logic [23:0] rnd_coord();
      case ($urandom_range(0, 3))
         0: return 24'($signed($urandom_range(0, 2000)) - 1000);
         1: return 24'($urandom);
         2: return ($urandom_range(0, 1)) ? 24'h7fffff : 24'h800000;
         default: return 24'($signed($urandom_range(0, 200000)) - 100000);
      endcase
   endfunction

   function automatic request_type rnd_figure(input logic [1:0] k);
      request_type r;
      r.action = ActLoad; r.kind = k;
      r.x1 = rnd_coord(); r.y1 = rnd_coord(); r.x2 = rnd_coord();
      r.y2 = rnd_coord(); r.x3 = rnd_coord(); r.y3 = rnd_coord();
      r.rad = ($urandom_range(0, 3) == 0) ? 23'($urandom) : 23'($urandom_range(0, 150000));
      r.px = rnd_coord(); r.py = rnd_coord();
      if (k == pift_pkg::KindRect && $urandom_range(0, 3) != 0) begin
         r.x1 = 24'($signed($urandom_range(0, 50000)) - 60000);
         r.x2 = 24'($signed($urandom_range(0, 50000)) + 10000);
         r.y2 = 24'($signed($urandom_range(0, 50000)) - 60000);
         r.y1 = 24'($signed($urandom_range(0, 50000)) + 10000);
      end
      return r;
   endfunction

   function automatic request_type rnd_point();
      request_type r;
      r = rnd_figure(2'($urandom));
      r.action = ActTest;
      if ($urandom_range(0, 2) != 0) begin
         r.px = 24'($signed($urandom_range(0, 160000)) - 80000);
         r.py = 24'($signed($urandom_range(0, 160000)) - 80000);
      end
      return r;
   endfunction

   function automatic request_type pt(input int x, input int y);
      request_type r;
      r = rnd_figure(pift_pkg::KindRect);
      r.action = ActTest; r.px = 24'(x); r.py = 24'(y);
      return r;
   endfunction

   initial begin
      request_type r;
      // directed: empty table, each kind incl. the spare code, boundaries, full table
      pending_reqs.push_back(pt(0, 0));
      r = rnd_figure(pift_pkg::KindRect);
      r.x1 = -24'sd100; r.y1 = 24'sd100; r.x2 = 24'sd100; r.y2 = -24'sd100;
      pending_reqs.push_back(r);
      r = rnd_figure(pift_pkg::KindCircle);
      r.x1 = '0; r.y1 = '0; r.rad = 23'd50;
      pending_reqs.push_back(r);
      r = rnd_figure(KindTri);
      r.x1 = '0; r.y1 = '0; r.x2 = 24'sd200; r.y2 = '0; r.x3 = '0; r.y3 = 24'sd200;
      pending_reqs.push_back(r);
      r.kind = KindSpare;
      pending_reqs.push_back(r);
      r = rnd_figure(pift_pkg::KindCircle);
      r.x1 = 24'h800000; r.y1 = 24'h7fffff; r.rad = 23'h7fffff;
      pending_reqs.push_back(r);
      pending_reqs.push_back(pt(10, 10));
      pending_reqs.push_back(pt(100, 0));
      pending_reqs.push_back(pt(50, 0));
      pending_reqs.push_back(pt(30, 30));
      pending_reqs.push_back(pt(-99, 99));
      pending_reqs.push_back(pt(32'h7fffff, 32'h800000));
      pending_reqs.push_back(pt(32'hff800000, 32'h7fffff));
      pending_reqs.push_back(pt(32'hff800000, 32'h7ffff0));
      for (int i = 0; i < 12; i++) begin
         r = rnd_figure(pift_pkg::KindRect);
         r.x1 = 24'h800000; r.y1 = 24'h7fffff; r.x2 = 24'h7fffff; r.y2 = 24'h800000;
         pending_reqs.push_back(r);
      end
      pending_reqs.push_back(pt(1, 1));
      // random: tests of the full table dominate, loads there are dropped
      for (int i = 0; i < 103; i++) begin
         if ($urandom_range(0, 5) == 0) pending_reqs.push_back(rnd_figure(2'($urandom)));
         else pending_reqs.push_back(rnd_point());
      end
   end

   int req_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_hits(pending_reqs.pop_front());
            req_gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18));
            if ($urandom_range(0, 2) == 0) req_gap = 0;
         end
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tuser <= {pending_reqs[0].kind, pending_reqs[0].action};
            req_tdata <= {1'b0, pending_reqs[0].py, pending_reqs[0].px, pending_reqs[0].rad,
                          pending_reqs[0].y3, pending_reqs[0].x3, pending_reqs[0].y2,
                          pending_reqs[0].x2, pending_reqs[0].y1, pending_reqs[0].x1};
         end else begin
            req_tvalid <= 1'b0;
            stim_done <= 1'b1;
         end
      end
   end

   // one long hold-off so the response side backs up and req_ stalls
   initial begin
      wait (rsp_seen >= 20);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (400) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   int rsp_gap = 0;
   always @(posedge clock) begin
      response_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen++;
            if (expected_hits.size() == 0) begin
               report($sformatf("unexpected response %h", rsp_tdata));
            end else begin
               e = expected_hits.pop_front();
               if (rsp_tdata[15:0] !== e.point_no)
                  report($sformatf("point number %0d, want %0d", rsp_tdata[15:0], e.point_no));
               if (rsp_tdata[20:16] !== e.fig_no)
                  report($sformatf("figure number %0d, want %0d", rsp_tdata[20:16], e.fig_no));
               if (rsp_tdata[21] !== e.hit)
                  report($sformatf("contained %b, want %b", rsp_tdata[21], e.hit));
               if (rsp_tlast !== e.last)
                  report($sformatf("last %b, want %b", rsp_tlast, e.last));
            end
            rsp_gap = $urandom_range(0, 18);
            if ($urandom_range(0, 2) == 0) rsp_gap = 0;
         end
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done);
      wait (expected_hits.size() == 0);
      repeat (50) @(posedge clock);
      if (errors == 0 && expected_hits.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
`default_nettype wire

>>> filelist.f
rtl/core/pift_pkg.sv
rtl/core/pift_ram.sv
rtl/core/pift_eval.sv
rtl/core/point_in_figures_tester.sv
rtl/core/pift_checker.sv
verif/tb_point_in_figures_tester.sv
